[sv/quadrature_step_decoder_unit_assert.svh]
// Assertion macros shared by the checker of the quadrature step decoder.
// Depends on nothing; the including file supplies clock, reset and message.
`ifndef QUADRATURE_STEP_DECODER_UNIT_ASSERT_SVH
`define QUADRATURE_STEP_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QSD_ASSERT_NOW(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define QSD_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

[sv/qsd_pkg.sv]
// Shared types, register codes and the Gray-code transition table
// for the quadrature step decoder. No dependencies.
`default_nettype none

package qsd_pkg;

	localparam int CPS_W      = 4;
	localparam int LIM_W      = 7;
	localparam int ACC_W      = 5;
	localparam int PEND_W     = 8;
	localparam int IN_TDATA_W = 8;
	localparam int OUT_TDATA_W = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	localparam logic [CFG_IDX_W-1:0] REG_COUNTS_PER_STEP   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PENDING_LIMIT     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REVERSE_DIRECTION = 2'd2;

	localparam logic [CPS_W-1:0] CPS_RESET = 4'd2;
	localparam logic [LIM_W-1:0] LIM_RESET = 7'd8;
	localparam logic             REV_RESET = 1'b1;

	typedef logic signed [1:0] move_t;

	localparam move_t MOVE_NONE = 2'sb00;
	localparam move_t MOVE_FWD  = 2'sb01;
	localparam move_t MOVE_REV  = 2'sb11;

	typedef struct packed {
		logic [CPS_W-1:0] counts_per_step;
		logic [LIM_W-1:0] pending_limit;
		logic             reverse_direction;
	} cfg_t;

	typedef struct packed {
		logic take_step;
		logic level_b;
		logic level_a;
	} in_item_t;

	// has_pending lands in bit 0 of the packed item.
	typedef struct packed {
		logic signed [PEND_W-1:0] pending_after;
		move_t                    step_taken;
		logic                     has_pending;
	} out_item_t;

	// Index is {previous phase, current phase}, phase = {A, B}.
	function automatic move_t phase_move(input logic [3:0] idx);
		move_t m;
		case (idx) inside
			4'd2, 4'd4, 4'd11, 4'd13: m = MOVE_FWD;
			4'd1, 4'd7, 4'd8, 4'd14:  m = MOVE_REV;
			default:                  m = MOVE_NONE;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

[sv/qsd_move_decode.sv]
// Decodes one phase transition into a signed move with optional reversal.
// Depends on qsd_pkg for the transition table.
`default_nettype none

module qsd_move_decode (
	input  wire logic [1:0]     last_phase,
	input  wire logic [1:0]     phase,
	input  wire logic           reverse_direction,
	output qsd_pkg::move_t      move
);
	import qsd_pkg::*;

	move_t table_move;

	always_comb begin
		table_move = phase_move({last_phase, phase});
		move = reverse_direction ? -table_move : table_move;
	end

endmodule

`default_nettype wire

[sv/qsd_step_core.sv]
// Decoder state (phase, sub-step accumulator, pending detents) and its
// one-item update. Depends on qsd_pkg and qsd_move_decode.
`default_nettype none

module qsd_step_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire qsd_pkg::in_item_t  item,
	input  wire qsd_pkg::cfg_t      cfg,
	output qsd_pkg::out_item_t      result
);
	import qsd_pkg::*;

	logic [1:0]               last_phase_q;
	logic                     phase_valid_q;
	logic signed [ACC_W-1:0]  accum_q;
	logic signed [PEND_W-1:0] pending_q;

	logic [1:0]               phase;
	move_t                    move;
	logic                     counting;
	logic signed [ACC_W:0]    acc_sum;
	logic signed [ACC_W:0]    cps_pos;
	logic signed [ACC_W:0]    cps_neg;
	logic signed [PEND_W-1:0] lim_pos;
	logic signed [PEND_W-1:0] lim_neg;
	logic signed [ACC_W-1:0]  accum_next;
	logic signed [PEND_W-1:0] pend_mid;
	logic signed [PEND_W-1:0] pend_next;
	move_t                    taken;

	assign phase = {item.level_a, item.level_b};

	qsd_move_decode u_move (
		.last_phase        (last_phase_q),
		.phase             (phase),
		.reverse_direction (cfg.reverse_direction),
		.move              (move)
	);

	always_comb begin
		counting   = phase_valid_q && (phase != last_phase_q) && (move != MOVE_NONE);
		acc_sum    = $signed({accum_q[ACC_W-1], accum_q}) + $signed({{(ACC_W-1){move[1]}}, move});
		cps_pos    = $signed({2'b00, cfg.counts_per_step});
		cps_neg    = -cps_pos;
		lim_pos    = $signed({1'b0, cfg.pending_limit});
		lim_neg    = -lim_pos;
		accum_next = accum_q;
		pend_mid   = pending_q;
		if (counting) begin
			if (acc_sum >= cps_pos) begin
				if (pending_q < lim_pos)
					pend_mid = pending_q + 8'sd1;
				accum_next = '0;
			end else if (acc_sum <= cps_neg) begin
				if (pending_q > lim_neg)
					pend_mid = pending_q - 8'sd1;
				accum_next = '0;
			end else begin
				accum_next = acc_sum[ACC_W-1:0];
			end
		end

		// A take request moves the counter one detent toward zero.
		pend_next = pend_mid;
		taken     = MOVE_NONE;
		if (item.take_step) begin
			if (pend_mid > 8'sd0) begin
				pend_next = pend_mid - 8'sd1;
				taken     = MOVE_FWD;
			end else if (pend_mid < 8'sd0) begin
				pend_next = pend_mid + 8'sd1;
				taken     = MOVE_REV;
			end
		end

		result.has_pending   = (pend_mid != '0);
		result.step_taken    = taken;
		result.pending_after = pend_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_phase_q  <= '0;
			phase_valid_q <= 1'b0;
			accum_q       <= '0;
			pending_q     <= '0;
		end else if (en) begin
			last_phase_q  <= phase;
			phase_valid_q <= 1'b1;
			accum_q       <= accum_next;
			pending_q     <= pend_next;
		end
	end

endmodule

`default_nettype wire

[sv/quadrature_step_decoder_unit.sv]
// Quadrature step decoder: input register, step core and result register.
// Depends on qsd_pkg and qsd_step_core.
//
// Usage: each input beat on s_* carries one pin sample (level_a, level_b) and
// a take_step request. Every beat yields exactly one result beat on m_* with
// has_pending, step_taken and pending_after. The cfg channel writes
// counts_per_step (index 0), pending_limit (1) and reverse_direction (2);
// it is always ready and is meant to be written while no beat is in flight.
// An accepted input beat passes through the input register and then the
// result register before its result beat shows on m_tdata.
// Throughput is one beat per clock while m_tready does not stall the output.
// When m_tready is low the result register holds its beat and the input
// register can still take one more beat; s_tready then drops until the
// output drains. Reset clears both valid flags, the decoder state and the
// registers (2 transitions per detent, limit 8, reversed direction); the
// first sample after reset only latches the phase.
`default_nettype none

module quadrature_step_decoder_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// bit 0 level_a, bit 1 level_b, bit 2 take_step, bits 7:3 zero
	input  wire logic [qsd_pkg::IN_TDATA_W-1:0]    s_tdata,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// bit 0 has_pending, bits 2:1 step_taken, bits 10:3 pending_after, rest zero
	output logic [qsd_pkg::OUT_TDATA_W-1:0]        m_tdata,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [qsd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [qsd_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import qsd_pkg::*;

	cfg_t      cfg_q;
	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t item_s2;
	logic      valid_s2;
	out_item_t result;
	logic      advance;
	logic      fire;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.counts_per_step   <= CPS_RESET;
			cfg_q.pending_limit     <= LIM_RESET;
			cfg_q.reverse_direction <= REV_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_COUNTS_PER_STEP:   cfg_q.counts_per_step   <= cfg_data[CPS_W-1:0];
				REG_PENDING_LIMIT:     cfg_q.pending_limit     <= cfg_data[LIM_W-1:0];
				REG_REVERSE_DIRECTION: cfg_q.reverse_direction <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign advance  = !valid_s2 || m_tready;
	assign fire     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.level_a   <= s_tdata[0];
			item_s1.level_b   <= s_tdata[1];
			item_s1.take_step <= s_tdata[2];
		end
	end

	qsd_step_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (fire),
		.item   (item_s1),
		.cfg    (cfg_q),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire)
			item_s2 <= result;
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {{(OUT_TDATA_W - $bits(out_item_t)){1'b0}}, item_s2};

endmodule

`default_nettype wire

[sv/qsd_checker.sv]
// Port-level checker for the quadrature step decoder, bound to the top level.
// Depends on qsd_pkg and the assertion macro header.
`default_nettype none

`include "quadrature_step_decoder_unit_assert.svh"

module qsd_checker (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tready,
	input  wire logic                              m_tvalid,
	input  wire logic                              m_tready,
	input  wire logic [qsd_pkg::OUT_TDATA_W-1:0]   m_tdata
);

	// A stalled result beat stays put.
	`QSD_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata), "result beat changed while stalled")

	// With the output empty, the input register always has room.
	`QSD_ASSERT_NOW(a_ready_when_empty, clk, arst_n, !m_tvalid, s_tready,
		"input stalled with empty output")

	// Nothing pending before the take means nothing taken and nothing left.
	`QSD_ASSERT_NOW(a_idle_counter, clk, arst_n, m_tvalid && !m_tdata[0],
		m_tdata[2:1] == 2'b00 && m_tdata[10:3] == 8'h00,
		"counter moved without pending steps")

	// The taken step is none or a single detent of either sign.
	`QSD_ASSERT_NOW(a_step_code, clk, arst_n, m_tvalid, m_tdata[2:1] != 2'b10,
		"illegal step_taken code")

endmodule

bind quadrature_step_decoder_unit qsd_checker u_qsd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire

[dv/quadrature_step_decoder_unit_tb.sv]
// Self-checking testbench for quadrature_step_decoder_unit: drives pin samples and
// take requests on the input stream and compares each result beat with a local predictor.
// Depends on qsd_pkg and the RTL of the block; reads no files.
`default_nettype none

module quadrature_step_decoder_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import qsd_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_BEATS = 1800;
	localparam int LONG_HOLD    = 60;
	localparam int SETTLE       = 4;
	localparam int MAX_PRINTS   = 40;

	// Next phase {A, B} one count forward or backward in table terms.
	localparam logic [1:0] FWD_NEXT  [4] = '{2'd2, 2'd0, 2'd3, 2'd1};
	localparam logic [1:0] BACK_NEXT [4] = '{2'd1, 2'd3, 2'd0, 2'd2};

	typedef enum logic [0:0] {ROW_BEAT, ROW_REGS} row_kind_t;

	typedef struct packed {
		row_kind_t        kind;
		logic             a;
		logic             b;
		logic             take;
		logic [CPS_W-1:0] cps;
		logic [LIM_W-1:0] lim;
		logic             rev;
		logic             typed;
		out_item_t        want;
	} row_t;

	localparam out_item_t QUIET = '{8'sd0, MOVE_NONE, 1'b0};

	// Reset values are in force for the first rows; register rows take effect once drained.
	localparam row_t DIRECTED [26] = '{
		// first sample only latches, the take finds nothing pending
		'{ROW_BEAT, 1'b1, 1'b1, 1'b1, 4'd0, 7'd0, 1'b0, 1'b1, QUIET},
		'{ROW_BEAT, 1'b1, 1'b1, 1'b0, 4'd0, 7'd0, 1'b0, 1'b1, QUIET},
		// double jump counts nothing
		'{ROW_BEAT, 1'b0, 1'b0, 1'b0, 4'd0, 7'd0, 1'b0, 1'b1, QUIET},
		'{ROW_BEAT, 1'b0, 1'b1, 1'b0, 4'd0, 7'd0, 1'b0, 1'b0, QUIET},
		'{ROW_BEAT, 1'b1, 1'b1, 1'b0, 4'd0, 7'd0, 1'b0, 1'b0, QUIET},
		'{ROW_BEAT, 1'b1, 1'b0, 1'b1, 4'd0, 7'd0, 1'b0, 1'b0, QUIET},
		'{ROW_BEAT, 1'b0, 1'b0, 1'b0, 4'd0, 7'd0, 1'b0, 1'b0, QUIET},
		'{ROW_BEAT, 1'b1, 1'b1, 1'b0, 4'd0, 7'd0, 1'b0, 1'b0, QUIET},
		// zero step count with the smallest nonzero limit
		'{ROW_REGS, 1'b0, 1'b0, 1'b0, 4'd0, 7'd1, 1'b0, 1'b0, QUIET},
		'{ROW_BEAT, 1'b0, 1'b1, 1'b0, 4'd0, 7'd0, 1'b0, 1'b0, QUIET},
		'{ROW_BEAT, 1'b0, 1'b0, 1'b1, 4'd0, 7'd0, 1'b0, 1'b0, QUIET},
		'{ROW_BEAT, 1'b0, 1'b1, 1'b0, 4'd0, 7'd0, 1'b0, 1'b0, QUIET},
		'{ROW_BEAT, 1'b1, 1'b1, 1'b0, 4'd0, 7'd0, 1'b0, 1'b0, QUIET},
		'{ROW_BEAT, 1'b1, 1'b1, 1'b1, 4'd0, 7'd0, 1'b0, 1'b0, QUIET},
		// zero limit holds the counter at zero
		'{ROW_REGS, 1'b0, 1'b0, 1'b0, 4'd0, 7'd0, 1'b1, 1'b0, QUIET},
		'{ROW_BEAT, 1'b0, 1'b1, 1'b0, 4'd0, 7'd0, 1'b0, 1'b0, QUIET},
		'{ROW_BEAT, 1'b1, 1'b1, 1'b1, 4'd0, 7'd0, 1'b0, 1'b0, QUIET},
		'{ROW_REGS, 1'b0, 1'b0, 1'b0, 4'd0, 7'd127, 1'b0, 1'b0, QUIET},
		'{ROW_BEAT, 1'b0, 1'b1, 1'b0, 4'd0, 7'd0, 1'b0, 1'b0, QUIET},
		'{ROW_BEAT, 1'b0, 1'b0, 1'b0, 4'd0, 7'd0, 1'b0, 1'b0, QUIET},
		'{ROW_BEAT, 1'b1, 1'b0, 1'b0, 4'd0, 7'd0, 1'b0, 1'b0, QUIET},
		'{ROW_BEAT, 1'b1, 1'b1, 1'b0, 4'd0, 7'd0, 1'b0, 1'b0, QUIET},
		// limit written below the current count: kept, but no further growth
		'{ROW_REGS, 1'b0, 1'b0, 1'b0, 4'd1, 7'd2, 1'b0, 1'b0, QUIET},
		'{ROW_BEAT, 1'b0, 1'b1, 1'b0, 4'd0, 7'd0, 1'b0, 1'b0, QUIET},
		'{ROW_BEAT, 1'b0, 1'b0, 1'b1, 4'd0, 7'd0, 1'b0, 1'b0, QUIET},
		'{ROW_BEAT, 1'b0, 1'b1, 1'b0, 4'd0, 7'd0, 1'b0, 1'b0, QUIET}
	};

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	// Predictor state and its copy of the registers.
	logic [1:0]       seen_phase;
	bit               phase_known;
	int               sub_count;
	int               detents;
	logic [CPS_W-1:0] cps_reg;
	logic [LIM_W-1:0] lim_reg;
	logic             rev_reg;

	out_item_t expected_results [$];
	logic [1:0] pins;
	int burst_left;
	int hold_reqs;
	int hold_served;
	int beats_sent;
	int results_seen;
	int fail_count;
	int cycle_count;
	int settings_used;
	int peak_detents;
	int takes_served;

	always #10 clk = ~clk;

	quadrature_step_decoder_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// One tick of the decoder: phase transition, accumulation, saturation, then the take.
	function automatic out_item_t decode_tick(input in_item_t it);
		logic [1:0] ph;
		int         mv;
		out_item_t  r;
		ph = {it.level_a, it.level_b};
		mv = 0;
		if (!phase_known) begin
			phase_known = 1'b1;
			seen_phase = ph;
		end else if (ph != seen_phase) begin
			case ({seen_phase, ph})
				4'd2, 4'd4, 4'd11, 4'd13: mv = 1;
				4'd1, 4'd7, 4'd8, 4'd14:  mv = -1;
				default:                  mv = 0;
			endcase
			seen_phase = ph;
			if (mv != 0) begin
				if (rev_reg)
					mv = -mv;
				sub_count += mv;
				if (sub_count >= int'(cps_reg)) begin
					if (detents < int'(lim_reg))
						detents++;
					sub_count = 0;
				end else if (sub_count <= -int'(cps_reg)) begin
					if (detents > -int'(lim_reg))
						detents--;
					sub_count = 0;
				end
			end
		end
		r.has_pending = (detents != 0);
		r.step_taken = MOVE_NONE;
		if (it.take_step) begin
			if (detents > 0) begin
				detents--;
				r.step_taken = MOVE_FWD;
			end else if (detents < 0) begin
				detents++;
				r.step_taken = MOVE_REV;
			end
		end
		if (r.step_taken != MOVE_NONE)
			takes_served++;
		r.pending_after = detents[PEND_W-1:0];
		if (detents > peak_detents)
			peak_detents = detents;
		else if (-detents > peak_detents)
			peak_detents = -detents;
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		if (fail_count < MAX_PRINTS)
			$display("[%0t] mismatch on result beat %0d: %s", $realtime, results_seen, msg);
		fail_count++;
	endtask

	task automatic check_result(input logic [OUT_TDATA_W-1:0] data);
		out_item_t got;
		out_item_t want;
		got = data[$bits(out_item_t)-1:0];
		if (expected_results.size() == 0) begin
			report_mismatch("result beat with nothing expected");
			return;
		end
		want = expected_results.pop_front();
		results_seen++;
		if (got.has_pending !== want.has_pending)
			report_mismatch($sformatf("has_pending %b, expected %b",
				got.has_pending, want.has_pending));
		if (got.step_taken !== want.step_taken)
			report_mismatch($sformatf("step_taken %0d, expected %0d",
				got.step_taken, want.step_taken));
		if (got.pending_after !== want.pending_after)
			report_mismatch($sformatf("pending_after %0d, expected %0d",
				got.pending_after, want.pending_after));
		if (data[OUT_TDATA_W-1:$bits(out_item_t)] !== '0)
			report_mismatch($sformatf("padding bits %h not zero", data));
	endtask

	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready)
			check_result(m_tdata);

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, expected_results.size());
			$display("FAIL");
			$finish;
		end
	end

	// Receiver: stretches of fixed stall odds, plus a long hold-off on request.
	initial begin : receiver
		int stretch;
		int stall_pct;
		m_tready = 1'b0;
		forever begin
			stretch = $urandom_range(5, 60);
			case ($urandom_range(0, 3))
				0:       stall_pct = 0;
				1:       stall_pct = 20;
				2:       stall_pct = 50;
				default: stall_pct = 85;
			endcase
			repeat (stretch) begin
				@(posedge clk);
				if (hold_reqs != hold_served) begin
					m_tready <= 1'b0;
					repeat (LONG_HOLD - 1) @(posedge clk);
					hold_served++;
				end else begin
					m_tready <= ($urandom_range(0, 99) >= stall_pct);
				end
			end
		end
	end

	// Offers one beat after any idle gap and records its expected result on acceptance.
	task automatic offer_beat(input in_item_t it, input logic typed, input out_item_t want);
		int gap;
		out_item_t predicted;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= {{(IN_TDATA_W - $bits(in_item_t)){1'b0}}, it};
		do @(posedge clk); while (!s_tready);
		predicted = decode_tick(it);
		expected_results.push_back(typed ? want : predicted);
		pins = {it.level_a, it.level_b};
		beats_sent++;
	endtask

	// Stops offering and waits until every expected result has come back.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic set_regs(input logic [CPS_W-1:0] cps, input logic [LIM_W-1:0] lim,
			input logic rev);
		write_reg(REG_COUNTS_PER_STEP, CFG_DATA_W'(cps));
		write_reg(REG_PENDING_LIMIT, lim);
		write_reg(REG_REVERSE_DIRECTION, CFG_DATA_W'(rev));
		cfg_valid <= 1'b0;
		cps_reg = cps;
		lim_reg = lim;
		rev_reg = rev;
		settings_used++;
	endtask

	initial begin : stimulus
		in_item_t         it;
		logic [CPS_W-1:0] cps_pick;
		logic [LIM_W-1:0] lim_pick;
		logic             rev_pick;
		int               phase_no;
		int               random_sent;
		int               len;
		int               fwd_pct;
		int               take_pct;
		int               noise_pct;
		int               pause_at;

		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cps_reg = CPS_RESET;
		lim_reg = LIM_RESET;
		rev_reg = REV_RESET;
		phase_known = 1'b0;
		seen_phase = '0;
		sub_count = 0;
		detents = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i]) begin
			if (DIRECTED[i].kind == ROW_REGS) begin
				drain_results();
				set_regs(DIRECTED[i].cps, DIRECTED[i].lim, DIRECTED[i].rev);
			end else begin
				it.level_a = DIRECTED[i].a;
				it.level_b = DIRECTED[i].b;
				it.take_step = DIRECTED[i].take;
				offer_beat(it, DIRECTED[i].typed, DIRECTED[i].want);
			end
		end

		phase_no = 0;
		random_sent = 0;
		while (random_sent < RANDOM_BEATS) begin
			drain_results();
			fwd_pct = ($urandom_range(0, 2) == 0) ? 5 : (($urandom_range(0, 1) == 0) ? 50 : 95);
			case ($urandom_range(0, 3))
				0:       take_pct = 0;
				1:       take_pct = 15;
				2:       take_pct = 50;
				default: take_pct = 90;
			endcase
			noise_pct = $urandom_range(0, 25);
			len = $urandom_range(60, 200);
			pause_at = ($urandom_range(0, 3) == 0) ? len / 2 : -1;
			case (phase_no)
				0: set_regs(4'd15, 7'd127, 1'b1);
				1: set_regs(4'd0, 7'd0, 1'b0);
				2: set_regs(4'd1, 7'd1, 1'b0);
				5: begin
					// steady one-way turning until the widest limit saturates
					set_regs(4'd0, 7'd127, 1'b0);
					fwd_pct = 100;
					take_pct = 0;
					noise_pct = 0;
					len = 300;
				end
				default: begin
					case ($urandom_range(0, 4))
						0:       cps_pick = 4'd0;
						1:       cps_pick = 4'd1;
						2:       cps_pick = 4'd15;
						default: cps_pick = CPS_W'($urandom_range(2, 6));
					endcase
					case ($urandom_range(0, 4))
						0:       lim_pick = 7'd0;
						1:       lim_pick = 7'd1;
						2:       lim_pick = 7'd127;
						default: lim_pick = LIM_W'($urandom_range(2, 12));
					endcase
					rev_pick = 1'($urandom_range(0, 1));
					set_regs(cps_pick, lim_pick, rev_pick);
				end
			endcase
			if (phase_no == 3) begin
				// long receiver hold-off while beats keep coming, so the input backs up
				hold_reqs++;
				burst_left = 200;
			end
			if (phase_no == 4)
				pause_at = len / 3;
			for (int k = 0; k < len; k++) begin
				if (k == pause_at)
					drain_results();
				if ($urandom_range(0, 99) < noise_pct) begin
					case ($urandom_range(0, 2))
						0:       pins = pins;
						1:       pins = ~pins;
						default: pins = 2'($urandom_range(0, 3));
					endcase
				end else if ($urandom_range(0, 99) < fwd_pct) begin
					pins = FWD_NEXT[pins];
				end else begin
					pins = BACK_NEXT[pins];
				end
				it.level_a = pins[1];
				it.level_b = pins[0];
				it.take_step = ($urandom_range(0, 99) < take_pct);
				offer_beat(it, 1'b0, QUIET);
				random_sent++;
			end
			phase_no++;
		end

		drain_results();
		repeat (10) @(posedge clk);
		$display("Run covered %0d beats across %0d register settings, %0d results checked.",
			beats_sent, settings_used, results_seen);
		$display("Steps taken: %0d; largest pending magnitude: %0d; long hold-offs: %0d.",
			takes_served, peak_detents, hold_served);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

`default_nettype wire

[filelist.f]
+incdir+sv
sv/qsd_pkg.sv
sv/qsd_move_decode.sv
sv/qsd_step_core.sv
sv/quadrature_step_decoder_unit.sv
sv/qsd_checker.sv
dv/quadrature_step_decoder_unit_tb.sv
